// ===== design/sgcd_pkg.sv =====
// ----------------------------------------------------------------------------
// sgcd_pkg: shared types and constants of the stick gesture command detector
// Gesture codes, command codes, register indexes and the command sequences.
// ----------------------------------------------------------------------------
package sgcd_pkg;

  localparam int HIST_DEPTH = 7;
  localparam int NUM_CMDS   = 10;
  localparam int NUM_BASE   = 6;

  localparam int STICK_W  = 12;
  localparam int THRESH_W = 11;
  localparam int TIME_W   = 32;
  localparam int CMD_W    = 4;
  localparam int GEST_W   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [GEST_W-1:0] {
    G_CENTER = 3'd0,
    G_LEFT   = 3'd1,
    G_RIGHT  = 3'd2,
    G_DOWN   = 3'd3,
    G_UP     = 3'd4,
    G_IDLE   = 3'd5,
    G_OTHER  = 3'd6,
    G_LONG   = 3'd7
  } gesture_e;

  localparam logic [CMD_W-1:0] CMD_NONE = 4'd0;

  localparam logic [CFG_IDX_W-1:0] CFG_FULL_THRESH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_THRESH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HOLD      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_HOLD     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_HOLD     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TUNING_EN     = 3'd5;

  localparam logic [THRESH_W-1:0] FULL_THRESH_RST   = 11'd1434;
  localparam logic [THRESH_W-1:0] CENTER_THRESH_RST = 11'd410;
  localparam logic [TIME_W-1:0]   MIN_HOLD_RST      = 32'd100000;
  localparam logic [TIME_W-1:0]   LONG_HOLD_RST     = 32'd500000;
  localparam logic [TIME_W-1:0]   IDLE_HOLD_RST     = 32'd700000;

  typedef gesture_e seq_t [HIST_DEPTH];

  // Sequences oldest first; history entry i compares with column HIST_DEPTH-1-i.
  localparam seq_t CMD_TABLE [NUM_CMDS] = '{
    '{G_IDLE, G_DOWN,  G_CENTER, G_DOWN,  G_CENTER, G_DOWN,  G_CENTER},
    '{G_IDLE, G_UP,    G_CENTER, G_UP,    G_CENTER, G_UP,    G_CENTER},
    '{G_IDLE, G_LEFT,  G_CENTER, G_LEFT,  G_CENTER, G_UP,    G_CENTER},
    '{G_IDLE, G_LEFT,  G_CENTER, G_LEFT,  G_CENTER, G_DOWN,  G_CENTER},
    '{G_IDLE, G_RIGHT, G_CENTER, G_RIGHT, G_CENTER, G_UP,    G_CENTER},
    '{G_IDLE, G_RIGHT, G_CENTER, G_RIGHT, G_CENTER, G_DOWN,  G_CENTER},
    '{G_IDLE, G_UP,    G_CENTER, G_DOWN,  G_CENTER, G_UP,    G_CENTER},
    '{G_IDLE, G_UP,    G_CENTER, G_DOWN,  G_CENTER, G_DOWN,  G_CENTER},
    '{G_IDLE, G_UP,    G_CENTER, G_DOWN,  G_CENTER, G_RIGHT, G_CENTER},
    '{G_IDLE, G_UP,    G_CENTER, G_DOWN,  G_CENTER, G_LEFT,  G_CENTER}
  };

  typedef struct packed {
    logic [THRESH_W-1:0] full_thresh;
    logic [THRESH_W-1:0] center_thresh;
    logic [TIME_W-1:0]   min_hold;
    logic [TIME_W-1:0]   long_hold;
    logic [TIME_W-1:0]   idle_hold;
    logic                tuning_en;
  } cfg_t;

  typedef struct packed {
    logic     ground;
    gesture_e gesture;
  } gest_res_t;

endpackage

// ===== design/sgcd_classify.sv =====
// ----------------------------------------------------------------------------
// sgcd_classify: stick classification and dwell qualification
// Turns one stick sample into the raw gesture and the dwell-qualified gesture.
// ----------------------------------------------------------------------------
module sgcd_classify (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  sgcd_pkg::cfg_t                      cfg_i,
  input  logic signed [sgcd_pkg::STICK_W-1:0] roll_i,
  input  logic signed [sgcd_pkg::STICK_W-1:0] pitch_i,
  input  logic signed [sgcd_pkg::STICK_W-1:0] yaw_i,
  input  logic                                on_ground_i,
  input  logic [sgcd_pkg::TIME_W-1:0]         now_i,
  output sgcd_pkg::gest_res_t                 res_o
);

  localparam int EXT_W = sgcd_pkg::STICK_W + 1;

  sgcd_pkg::gesture_e          raw_q, raw_d;
  sgcd_pkg::gesture_e          prev_q, prev_d;
  sgcd_pkg::gesture_e          acc_q, acc_d;
  logic [sgcd_pkg::TIME_W-1:0] hold_q, hold_d;

  logic signed [EXT_W-1:0] roll_x, pitch_x, yaw_x, full_x, neg_full;
  logic [EXT_W-1:0]        roll_m, pitch_m, yaw_m, cen_x;
  logic                    left, right, xcen, down, up, pcen, changed;
  logic [sgcd_pkg::TIME_W-1:0] held;

  assign roll_x   = EXT_W'(roll_i);
  assign pitch_x  = EXT_W'(pitch_i);
  assign yaw_x    = EXT_W'(yaw_i);
  assign full_x   = $signed({2'b00, cfg_i.full_thresh});
  assign neg_full = -full_x;
  assign cen_x    = {2'b00, cfg_i.center_thresh};

  // Magnitudes fit 13 bits, including the most negative sample.
  assign roll_m  = roll_x[EXT_W-1]  ? EXT_W'(-roll_x)  : EXT_W'(roll_x);
  assign pitch_m = pitch_x[EXT_W-1] ? EXT_W'(-pitch_x) : EXT_W'(pitch_x);
  assign yaw_m   = yaw_x[EXT_W-1]   ? EXT_W'(-yaw_x)   : EXT_W'(yaw_x);

  assign left  = (roll_x < neg_full) || (yaw_x < neg_full);
  assign right = (roll_x > full_x) || (yaw_x > full_x);
  assign xcen  = (roll_m < cen_x) && (yaw_m < cen_x);
  assign down  = pitch_x < neg_full;
  assign up    = pitch_x > full_x;
  assign pcen  = pitch_m < cen_x;

  always_comb begin
    raw_d  = raw_q;
    prev_d = prev_q;
    acc_d  = acc_q;
    hold_d = hold_q;
    held   = '0;
    if (on_ground_i) begin
      if (xcen && pcen) begin
        raw_d = sgcd_pkg::G_CENTER;
      end else if (left && pcen) begin
        raw_d = sgcd_pkg::G_LEFT;
      end else if (right && pcen) begin
        raw_d = sgcd_pkg::G_RIGHT;
      end else if (down && xcen) begin
        raw_d = sgcd_pkg::G_DOWN;
      end else if (up && xcen) begin
        raw_d = sgcd_pkg::G_UP;
      end
      // A fresh raw gesture restarts the dwell at zero.
      changed = raw_d != prev_q;
      if (changed) begin
        hold_d = now_i;
      end else begin
        held = now_i - hold_q;
      end
      if (held > cfg_i.min_hold) begin
        if (raw_d == sgcd_pkg::G_CENTER && held > cfg_i.idle_hold) begin
          acc_d = sgcd_pkg::G_IDLE;
        end else if (held > cfg_i.long_hold) begin
          acc_d = sgcd_pkg::G_LONG;
        end else begin
          acc_d = raw_d;
        end
      end
      prev_d = raw_d;
    end else begin
      changed = 1'b0;
      acc_d   = sgcd_pkg::G_OTHER;
      prev_d  = sgcd_pkg::G_OTHER;
    end
  end

  assign res_o.ground  = on_ground_i;
  assign res_o.gesture = acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q  <= sgcd_pkg::G_CENTER;
      prev_q <= sgcd_pkg::G_CENTER;
      acc_q  <= sgcd_pkg::G_CENTER;
      hold_q <= '0;
    end else if (en_i) begin
      raw_q  <= raw_d;
      prev_q <= prev_d;
      acc_q  <= acc_d;
      hold_q <= hold_d;
    end
  end

endmodule

// ===== design/sgcd_hist_cell.sv =====
// ----------------------------------------------------------------------------
// sgcd_hist_cell: one entry of the gesture history chain
// Holds one gesture, takes its neighbor's on a shift and matches its column.
// ----------------------------------------------------------------------------
module sgcd_hist_cell #(
  parameter int IDX = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          shift_i,
  input  logic                          poison_i,
  input  sgcd_pkg::gesture_e            din_i,
  output sgcd_pkg::gesture_e            q_o,
  output logic [sgcd_pkg::NUM_CMDS-1:0] match_o
);

  sgcd_pkg::gesture_e q_q, q_d, val;

  assign val = shift_i ? din_i : q_q;

  always_comb begin
    for (int k = 0; k < sgcd_pkg::NUM_CMDS; k++) begin
      match_o[k] = val == sgcd_pkg::CMD_TABLE[k][sgcd_pkg::HIST_DEPTH-1-IDX];
    end
  end

  assign q_d = poison_i ? sgcd_pkg::G_OTHER : val;
  assign q_o = q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q <= sgcd_pkg::G_CENTER;
    end else if (en_i) begin
      q_q <= q_d;
    end
  end

endmodule

// ===== design/stick_gesture_command_detector.sv =====
// ----------------------------------------------------------------------------
// stick_gesture_command_detector: stick gesture to command decoder
// Classifies stick samples, qualifies them by dwell, keeps a seven-entry
// gesture history in a chain of cells and matches it to command sequences.
// ----------------------------------------------------------------------------
// A result is registered in the output register, or in the skid while the
//   output stalls. Throughput: one request per cycle while the skid is free;
//   classify, dwell, shift and match sit between the input handshake and
//   the output register. A two-entry output stage (output register plus skid)
//   keeps the slave side open for one more request while a result waits.
// Reset: registers at their defaults, history all center, no pending result.
// ----------------------------------------------------------------------------
module stick_gesture_command_detector (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // slave side
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // roll_stick[11:0], pitch_stick[23:12], yaw_stick[35:24], on_ground[36],
  // now_us[68:37], zero fill [71:69]
  input  logic [sgcd_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // master side
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // command_code[3:0], qualified_gesture[6:4], zero fill [7]
  output logic [sgcd_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [sgcd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sgcd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int HD = sgcd_pkg::HIST_DEPTH;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  sgcd_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.full_thresh   <= sgcd_pkg::FULL_THRESH_RST;
      cfg_q.center_thresh <= sgcd_pkg::CENTER_THRESH_RST;
      cfg_q.min_hold      <= sgcd_pkg::MIN_HOLD_RST;
      cfg_q.long_hold     <= sgcd_pkg::LONG_HOLD_RST;
      cfg_q.idle_hold     <= sgcd_pkg::IDLE_HOLD_RST;
      cfg_q.tuning_en     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sgcd_pkg::CFG_FULL_THRESH:   cfg_q.full_thresh <= cfg_data_i[sgcd_pkg::THRESH_W-1:0];
        sgcd_pkg::CFG_CENTER_THRESH: begin
          cfg_q.center_thresh <= cfg_data_i[sgcd_pkg::THRESH_W-1:0];
        end
        sgcd_pkg::CFG_MIN_HOLD:      cfg_q.min_hold  <= cfg_data_i;
        sgcd_pkg::CFG_LONG_HOLD:     cfg_q.long_hold <= cfg_data_i;
        sgcd_pkg::CFG_IDLE_HOLD:     cfg_q.idle_hold <= cfg_data_i;
        sgcd_pkg::CFG_TUNING_EN:     cfg_q.tuning_en <= cfg_data_i[0];
        default: ; // unknown index: drop the write
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input unpacking and request acceptance
  // --------------------------------------------------------------------------
  logic                                accept;
  logic signed [sgcd_pkg::STICK_W-1:0] roll, pitch, yaw;
  logic                                on_ground;
  logic [sgcd_pkg::TIME_W-1:0]         now_us;

  assign accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign roll      = $signed(s_axis_tdata_i[11:0]);
  assign pitch     = $signed(s_axis_tdata_i[23:12]);
  assign yaw       = $signed(s_axis_tdata_i[35:24]);
  assign on_ground = s_axis_tdata_i[36];
  assign now_us    = s_axis_tdata_i[68:37];

  // --------------------------------------------------------------------------
  // Classification and dwell qualification
  // --------------------------------------------------------------------------
  sgcd_pkg::gest_res_t gres;

  sgcd_classify u_classify (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (accept),
    .cfg_i       (cfg_q),
    .roll_i      (roll),
    .pitch_i     (pitch),
    .yaw_i       (yaw),
    .on_ground_i (on_ground),
    .now_i       (now_us),
    .res_o       (gres)
  );

  // --------------------------------------------------------------------------
  // History chain: cell 0 is the newest entry. Advance the chain only when
  // the qualified gesture differs from the newest entry and the craft is
  // on the ground. Each cell reports which command columns it matches.
  // --------------------------------------------------------------------------
  sgcd_pkg::gesture_e            hist   [HD];
  sgcd_pkg::gesture_e            chain_in [HD];
  logic [sgcd_pkg::NUM_CMDS-1:0] cell_match [HD];
  logic                          push;
  logic                          poison;

  assign push = gres.ground && (gres.gesture != hist[0]);

  for (genvar i = 0; i < HD; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign chain_in[i] = gres.gesture;
    end else begin : g_body
      assign chain_in[i] = hist[i-1];
    end

    sgcd_hist_cell #(
      .IDX (i)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (accept),
      .shift_i  (push),
      .poison_i ((i == 1) ? poison : 1'b0),
      .din_i    (chain_in[i]),
      .q_o      (hist[i]),
      .match_o  (cell_match[i])
    );
  end

  // --------------------------------------------------------------------------
  // Command match: a command fires when every cell agrees; the lowest code
  // wins. A hit overwrites entry one with "other" so it cannot refire.
  // --------------------------------------------------------------------------
  logic [sgcd_pkg::NUM_CMDS-1:0] cmd_hit;
  logic [sgcd_pkg::CMD_W-1:0]    cmd_code;

  always_comb begin
    cmd_hit = {sgcd_pkg::NUM_CMDS{push}};
    for (int i = 0; i < HD; i++) begin
      cmd_hit = cmd_hit & cell_match[i];
    end
    if (!cfg_q.tuning_en) begin
      cmd_hit[sgcd_pkg::NUM_CMDS-1:sgcd_pkg::NUM_BASE] = '0;
    end
  end

  always_comb begin
    cmd_code = sgcd_pkg::CMD_NONE;
    for (int k = sgcd_pkg::NUM_CMDS - 1; k >= 0; k--) begin
      if (cmd_hit[k]) begin
        cmd_code = sgcd_pkg::CMD_W'(k + 1);
      end
    end
  end

  assign poison = cmd_code != sgcd_pkg::CMD_NONE;

  // --------------------------------------------------------------------------
  // Output stage: output register plus one skid entry. Hold the slave side
  // only while the skid entry is occupied.
  // --------------------------------------------------------------------------
  logic [sgcd_pkg::OUT_DATA_W-1:0] result;
  logic                            out_vld_q, out_vld_d;
  logic [sgcd_pkg::OUT_DATA_W-1:0] out_dat_q, out_dat_d;
  logic                            skid_vld_q, skid_vld_d;
  logic [sgcd_pkg::OUT_DATA_W-1:0] skid_dat_q, skid_dat_d;

  assign result = {1'b0, gres.gesture, cmd_code};

  always_comb begin
    out_vld_d  = out_vld_q;
    out_dat_d  = out_dat_q;
    skid_vld_d = skid_vld_q;
    skid_dat_d = skid_dat_q;
    if (!out_vld_q || m_axis_tready_i) begin
      if (skid_vld_q) begin
        out_vld_d  = 1'b1;
        out_dat_d  = skid_dat_q;
        skid_vld_d = 1'b0;
      end else begin
        out_vld_d = accept;
        out_dat_d = result;
      end
    end else if (accept) begin
      skid_vld_d = 1'b1;
      skid_dat_d = result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_dat_q  <= out_dat_d;
    skid_dat_q <= skid_dat_d;
  end

  assign s_axis_tready_o = !skid_vld_q;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_dat_q;

endmodule

// ===== tb/stick_gesture_command_detector_tb.sv =====
// ----------------------------------------------------------------------------
// stick_gesture_command_detector_tb: self-checking bench for the gesture decoder
// Streams stick samples through the block, tracks the classification, dwell
// qualification, history and sequence matching in a local predictor, and checks
// every command code and qualified gesture against it under random idling,
// long output stalls and a range of register settings.
// ----------------------------------------------------------------------------
module stick_gesture_command_detector_tb;
  import sgcd_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  // Indexes past the end of the register list; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef enum logic [CMD_W-1:0] {
    CMD_DDD = 4'd1, CMD_UUU, CMD_LLU, CMD_LLD, CMD_RRU,
    CMD_RRD, CMD_UDU, CMD_UDD, CMD_UDR, CMD_UDL
  } command_e;

  typedef struct {
    logic signed [STICK_W-1:0] roll;
    logic signed [STICK_W-1:0] pitch;
    logic signed [STICK_W-1:0] yaw;
    logic                      ground;
    logic [TIME_W-1:0]         now;
  } stick_sample_t;

  typedef struct {
    logic [CMD_W-1:0] code;
    gesture_e         gest;
  } gesture_report_t;

  // Command sequences, oldest gesture first; row k reports command_codes[k].
  gesture_e command_seqs [NUM_CMDS][HIST_DEPTH] = '{
    '{G_IDLE, G_DOWN,  G_CENTER, G_DOWN,  G_CENTER, G_DOWN,  G_CENTER},
    '{G_IDLE, G_UP,    G_CENTER, G_UP,    G_CENTER, G_UP,    G_CENTER},
    '{G_IDLE, G_LEFT,  G_CENTER, G_LEFT,  G_CENTER, G_UP,    G_CENTER},
    '{G_IDLE, G_LEFT,  G_CENTER, G_LEFT,  G_CENTER, G_DOWN,  G_CENTER},
    '{G_IDLE, G_RIGHT, G_CENTER, G_RIGHT, G_CENTER, G_UP,    G_CENTER},
    '{G_IDLE, G_RIGHT, G_CENTER, G_RIGHT, G_CENTER, G_DOWN,  G_CENTER},
    '{G_IDLE, G_UP,    G_CENTER, G_DOWN,  G_CENTER, G_UP,    G_CENTER},
    '{G_IDLE, G_UP,    G_CENTER, G_DOWN,  G_CENTER, G_DOWN,  G_CENTER},
    '{G_IDLE, G_UP,    G_CENTER, G_DOWN,  G_CENTER, G_RIGHT, G_CENTER},
    '{G_IDLE, G_UP,    G_CENTER, G_DOWN,  G_CENTER, G_LEFT,  G_CENTER}
  };
  command_e command_codes [NUM_CMDS] = '{
    CMD_DDD, CMD_UUU, CMD_LLU, CMD_LLD, CMD_RRU,
    CMD_RRD, CMD_UDU, CMD_UDD, CMD_UDR, CMD_UDL
  };

  // DUT signals
  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // Predictor state: register copy, gesture tracking and history.
  cfg_t              shadow_cfg;
  gesture_e          trk_raw;
  gesture_e          trk_prev_raw;
  gesture_e          trk_accepted;
  logic [TIME_W-1:0] trk_hold_start;
  gesture_e          trk_history [HIST_DEPTH];

  gesture_report_t   due_reports [$];

  // Bench bookkeeping
  logic [TIME_W-1:0] now_us;
  int                items_sent;
  int                mismatches;
  int                cycles;
  bit                tx_idle_en;
  bit                rx_idle_en;
  int                rx_hold_req;
  int                rx_stall_left;

  stick_gesture_command_detector u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Random helpers
  // --------------------------------------------------------------------------
  function int rand_between(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo, 0));
  endfunction

  // Favor the ends of the stick range and zero, otherwise anything.
  function int pick_stick();
    case ($urandom_range(0, 7))
      0:       return -2048;
      1:       return 2047;
      2:       return 0;
      3:       return -1;
      default: return int'($urandom_range(0, 4095)) - 2048;
    endcase
  endfunction

  // Strictly inside the center band; a zero band has no inside.
  function int pick_center(input int cen);
    if (cen == 0) return 0;
    return rand_between(-(cen - 1), cen - 1);
  endfunction

  function stick_sample_t sample(input int roll, input int pitch, input int yaw,
                                 input bit ground, input logic [TIME_W-1:0] t);
    stick_sample_t s;
    s.roll   = 12'(roll);
    s.pitch  = 12'(pitch);
    s.yaw    = 12'(yaw);
    s.ground = ground;
    s.now    = t;
    return s;
  endfunction

  // Any field value at all; time mostly advances, now and then jumps anywhere.
  function stick_sample_t noise_sample();
    stick_sample_t s;
    if ($urandom_range(0, 9) == 0) now_us = $urandom();
    else now_us = now_us + 32'($urandom_range(0, 400000));
    s = sample(pick_stick(), pick_stick(), pick_stick(), $urandom_range(0, 5) != 0, now_us);
    return s;
  endfunction

  // Stick position that classifies as gesture g under the current thresholds.
  // Anything that is not a direction gives a centered stick.
  // Assumes center_thresh <= full_thresh <= 2046, as the random settings keep.
  function stick_sample_t make_pose(input gesture_e g);
    stick_sample_t s;
    int full;
    int cen;
    int pick;
    full = int'(shadow_cfg.full_thresh);
    cen  = int'(shadow_cfg.center_thresh);
    s = sample(pick_center(cen), pick_center(cen), pick_center(cen), 1'b1, now_us);
    pick = rand_between(0, 2);
    case (g)
      G_LEFT, G_RIGHT: begin
        // Drive roll, yaw or both past the threshold on the chosen side.
        if (pick != 1) begin
          s.roll = (g == G_LEFT) ? 12'(-2048 + rand_between(0, 2047 - full))
                                 : 12'(full + 1 + rand_between(0, 2046 - full));
        end
        if (pick != 0) begin
          s.yaw = (g == G_LEFT) ? 12'(-2048 + rand_between(0, 2047 - full))
                                : 12'(full + 1 + rand_between(0, 2046 - full));
        end
      end
      G_DOWN: s.pitch = 12'(-2048 + rand_between(0, 2047 - full));
      G_UP:   s.pitch = 12'(full + 1 + rand_between(0, 2046 - full));
      default: ;
    endcase
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Predictor: classify, qualify by dwell, shift history, match sequences.
  // --------------------------------------------------------------------------
  function void reset_tracking();
    shadow_cfg.full_thresh   = 11'd1434;
    shadow_cfg.center_thresh = 11'd410;
    shadow_cfg.min_hold      = 32'd100000;
    shadow_cfg.long_hold     = 32'd500000;
    shadow_cfg.idle_hold     = 32'd700000;
    shadow_cfg.tuning_en     = 1'b0;
    trk_raw        = G_CENTER;
    trk_prev_raw   = G_CENTER;
    trk_accepted   = G_CENTER;
    trk_hold_start = '0;
    foreach (trk_history[i]) trk_history[i] = G_CENTER;
  endfunction

  function gesture_report_t decode_sample(input stick_sample_t s);
    gesture_report_t rep;
    int r, p, y, full, cen, n_seq;
    bit left, right, xcen, down, up, pcen, hit, found;
    logic [TIME_W-1:0] held;
    r    = int'(s.roll);
    p    = int'(s.pitch);
    y    = int'(s.yaw);
    full = int'(shadow_cfg.full_thresh);
    cen  = int'(shadow_cfg.center_thresh);
    rep.code = CMD_NONE;
    found = 1'b0;
    if (s.ground) begin
      left  = (r < -full) || (y < -full);
      right = (r > full) || (y > full);
      xcen  = ((r < 0 ? -r : r) < cen) && ((y < 0 ? -y : y) < cen);
      down  = p < -full;
      up    = p > full;
      pcen  = (p < 0 ? -p : p) < cen;
      // Unclassified positions leave the raw gesture as it was.
      if (xcen && pcen)       trk_raw = G_CENTER;
      else if (left && pcen)  trk_raw = G_LEFT;
      else if (right && pcen) trk_raw = G_RIGHT;
      else if (down && xcen)  trk_raw = G_DOWN;
      else if (up && xcen)    trk_raw = G_UP;

      if (trk_raw != trk_prev_raw) trk_hold_start = s.now;
      held = s.now - trk_hold_start;   // wraps modulo 2^32
      if (held > shadow_cfg.min_hold) begin
        if (trk_raw == G_CENTER && held > shadow_cfg.idle_hold) trk_accepted = G_IDLE;
        else if (held > shadow_cfg.long_hold)                   trk_accepted = G_LONG;
        else                                                    trk_accepted = trk_raw;
      end
      trk_prev_raw = trk_raw;

      // Shift only on a change of the accepted gesture, then match.
      if (trk_accepted != trk_history[0]) begin
        for (int i = HIST_DEPTH - 1; i >= 1; i--) trk_history[i] = trk_history[i - 1];
        trk_history[0] = trk_accepted;
        n_seq = shadow_cfg.tuning_en ? NUM_CMDS : NUM_BASE;
        for (int k = 0; k < n_seq; k++) begin
          if (!found) begin
            hit = 1'b1;
            for (int i = 0; i < HIST_DEPTH; i++) begin
              if (trk_history[i] != command_seqs[k][HIST_DEPTH - 1 - i]) hit = 1'b0;
            end
            if (hit) begin
              // Poison entry one so the same sequence cannot fire again at once.
              found          = 1'b1;
              trk_history[1] = G_OTHER;
              rep.code       = command_codes[k];
            end
          end
        end
      end
    end else begin
      // Airborne: report other and restart tracking; history is kept.
      trk_accepted = G_OTHER;
      trk_prev_raw = G_OTHER;
    end
    rep.gest = trk_accepted;
    return rep;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Offer one request, with a random idle burst ahead of it, and hold it until
  // accepted. Valid stays high into the next call when there is no gap.
  task send_sample(input stick_sample_t s);
    int gap;
    gap = (tx_idle_en && $urandom_range(0, 3) == 0) ? rand_between(1, 4) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {3'b000, s.now, s.ground, s.yaw, s.pitch, s.roll};
    do @(posedge clk_i); while (!s_axis_tready_o);
    due_reports.push_back(decode_sample(s));
    items_sent++;
  endtask

  // Drop valid and hold until every pending report has come back.
  task wait_drained();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk_i);
  endtask

  // Registers are written only with nothing in flight.
  task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_FULL_THRESH:   shadow_cfg.full_thresh   = value[THRESH_W-1:0];
      CFG_CENTER_THRESH: shadow_cfg.center_thresh = value[THRESH_W-1:0];
      CFG_MIN_HOLD:      shadow_cfg.min_hold      = value;
      CFG_LONG_HOLD:     shadow_cfg.long_hold     = value;
      CFG_IDLE_HOLD:     shadow_cfg.idle_hold     = value;
      CFG_TUNING_EN:     shadow_cfg.tuning_en     = value[0];
      default: ;
    endcase
  endtask

  task write_all_regs(input logic [31:0] full, input logic [31:0] cen,
                      input logic [31:0] min_h, input logic [31:0] long_h,
                      input logic [31:0] idle_h, input logic [31:0] tuning);
    wait_drained();
    write_reg(CFG_FULL_THRESH, full);
    write_reg(CFG_CENTER_THRESH, cen);
    write_reg(CFG_MIN_HOLD, min_h);
    write_reg(CFG_LONG_HOLD, long_h);
    write_reg(CFG_IDLE_HOLD, idle_h);
    write_reg(CFG_TUNING_EN, tuning);
  endtask

  // Thresholds and dwell limits under which every gesture can be reached:
  // center band inside the deflection threshold, min below long and idle.
  task apply_random_config(input bit tuning);
    int cen;
    int min_h;
    cen   = rand_between(1, 1000);
    min_h = rand_between(0, 200000);
    write_all_regs(32'(rand_between(cen, 2046)), 32'(cen), 32'(min_h),
                   32'(min_h + rand_between(2, 400000)),
                   32'(min_h + rand_between(2, 600000)), 32'(tuning));
  endtask

  // Hold one gesture long enough to be accepted as itself (or as center-idle
  // for G_IDLE), with a few samples along the way. Cut short to break a run.
  task hold_pose(input gesture_e g, input bit cut_short);
    logic [TIME_W-1:0] t0;
    stick_sample_t s;
    int min_h, lim, dwell, n_mid;
    min_h = int'(shadow_cfg.min_hold);
    if (g == G_IDLE) begin
      dwell = int'(shadow_cfg.idle_hold) + 1 + rand_between(0, 20000);
    end else begin
      lim = int'(shadow_cfg.long_hold);
      if (g == G_CENTER && shadow_cfg.idle_hold < shadow_cfg.long_hold)
        lim = int'(shadow_cfg.idle_hold);
      dwell = rand_between(min_h + 1, lim);
    end
    if (cut_short) dwell = rand_between(0, min_h);
    now_us = now_us + 32'(rand_between(1, 50));
    t0 = now_us;
    s = make_pose(g);
    s.now = t0;
    send_sample(s);
    n_mid = rand_between(0, 2);
    for (int j = 1; j <= n_mid; j++) begin
      s = make_pose(g);
      s.now = t0 + 32'(dwell * j / (n_mid + 1));
      send_sample(s);
    end
    s = make_pose(g);
    s.now = t0 + 32'(dwell);
    send_sample(s);
    now_us = s.now;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, plus a long hold-off on request.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rx_hold_req > 0) begin
      rx_stall_left = rx_hold_req;
      rx_hold_req   = 0;
    end
    if (rx_stall_left > 0) begin
      m_axis_tready_i <= 1'b0;
      rx_stall_left--;
    end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
      m_axis_tready_i <= 1'b0;
      rx_stall_left = rand_between(0, 3);
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Checker: compare each accepted result with the oldest pending report.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_reports
    gesture_report_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (due_reports.size() == 0) begin
        $display("%0t: result with no request pending, got %h", $time, m_axis_tdata_o);
        mismatches++;
      end else begin
        want = due_reports.pop_front();
        if (m_axis_tdata_o[3:0] != want.code) begin
          $display("%0t: command_code expected %0d got %0d", $time, want.code,
                   m_axis_tdata_o[3:0]);
          mismatches++;
        end
        if (m_axis_tdata_o[6:4] != want.gest) begin
          $display("%0t: qualified_gesture expected %0d got %0d", $time, want.gest,
                   m_axis_tdata_o[6:4]);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: a missing result or a stuck handshake ends the run here.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("stick_gesture_command_detector_tb failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset settings: dwell edges, a full down-down-down command, every
  // classification, threshold ties, airborne, time wrap and a long hold.
  task test_directed();
    send_sample(sample(0, 0, 0, 1, 32'd100000));            // held exactly min
    send_sample(sample(0, 0, 0, 1, 32'd700000));            // past long, at idle
    send_sample(sample(0, 0, 0, 1, 32'd700001));            // center-idle
    send_sample(sample(409, -2048, -409, 1, 32'd800000));   // down, edge of band
    send_sample(sample(0, -1435, 0, 1, 32'd900001));
    send_sample(sample(0, -409, 0, 1, 32'd900002));
    send_sample(sample(0, 0, 0, 1, 32'd1000003));
    send_sample(sample(0, -1435, 0, 1, 32'd1000004));
    send_sample(sample(0, -2000, 0, 1, 32'd1100005));
    send_sample(sample(0, 0, 0, 1, 32'd1100006));
    send_sample(sample(0, 0, 0, 1, 32'd1200007));
    send_sample(sample(0, -1435, 0, 1, 32'd1200008));
    send_sample(sample(0, -1435, 0, 1, 32'd1300009));
    send_sample(sample(0, 0, 0, 1, 32'd1300010));
    send_sample(sample(0, 0, 0, 1, 32'd1400011));           // sequence completes
    send_sample(sample(-2048, 0, 0, 1, 32'd1400012));       // left by roll
    send_sample(sample(0, 0, 2047, 1, 32'd1400013));        // right by yaw
    send_sample(sample(0, 2047, 0, 1, 32'd1400014));        // up
    send_sample(sample(1435, 1435, 0, 1, 32'd1400015));     // diagonal: unclassified
    send_sample(sample(1434, 0, 0, 1, 32'd1500015));        // on threshold: unclassified
    send_sample(sample(-1, -1, -1, 0, 32'd1500016));        // airborne
    send_sample(sample(0, 0, 0, 1, 32'hFFFF_FFF0));
    send_sample(sample(0, 0, 0, 1, 32'd99985));             // dwell across the wrap
    send_sample(sample(0, 0, -1435, 1, 32'd99986));         // left by yaw
    send_sample(sample(-2048, 0, -2048, 1, 32'd600000));    // long hold
    now_us = 32'd600000;
  endtask

  // Well-formed command sequences with random content; some are broken by
  // a stray sample or a short dwell, some ask for a disabled tuning command.
  task test_command_sequences(input int n_items, input bit tuning, input bit reconfigure);
    int stop_at, k, cut_at;
    if (reconfigure) apply_random_config(tuning);
    if ($urandom_range(0, 1)) now_us = 32'hFFFF_FFFF - 32'($urandom_range(0, 3000000));
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 5) == 0) k = rand_between(0, NUM_CMDS - 1);
      else k = rand_between(0, (tuning ? NUM_CMDS : NUM_BASE) - 1);
      cut_at = ($urandom_range(0, 4) == 0) ? rand_between(0, HIST_DEPTH - 1) : -1;
      for (int j = 0; j < HIST_DEPTH; j++) begin
        if (j == cut_at && $urandom_range(0, 1)) begin
          send_sample(noise_sample());
          hold_pose(command_seqs[k][j], 1'b0);
        end else begin
          hold_pose(command_seqs[k][j], j == cut_at);
        end
      end
      if ($urandom_range(0, 3) == 0) send_sample(noise_sample());
    end
  endtask

  // Unstructured samples, airborne ones among them, under random settings.
  task test_noise(input int n_items);
    apply_random_config($urandom_range(0, 1) != 0);
    repeat (n_items) send_sample(noise_sample());
  endtask

  // Register extremes, masking of wide write data and writes to spare indexes.
  task test_config_extremes();
    // Zero thresholds and zero dwell: nothing is centered, any dwell is long.
    write_all_regs(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1);
    repeat (60) send_sample(noise_sample());
    // All ones: thresholds mask to 2047, dwell never qualifies, tuning off.
    write_all_regs('1, '1, '1, '1, '1, 32'hFFFF_FFFE);
    write_reg(CFG_SPARE_LO, $urandom());
    write_reg(CFG_SPARE_HI, $urandom());
    repeat (60) send_sample(noise_sample());
    // Center band wider than the deflection threshold, instant idle.
    write_all_regs(32'hFFFF_F800 | 32'd700, 32'd2000, 32'd0, '1, 32'd0, 32'd1);
    write_reg(CFG_SPARE_HI, '1);
    repeat (60) send_sample(noise_sample());
  endtask

  // Hold the receiver off long enough for the block to fill and stall its
  // slave side while requests keep coming, then pause until all are back.
  task test_output_backpressure();
    apply_random_config(1'b1);
    rx_hold_req = 60;
    repeat (40) send_sample(noise_sample());
    wait_drained();
    repeat (20) send_sample(noise_sample());
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_FULL_THRESH;
    cfg_data_i      = '0;
    now_us          = '0;
    items_sent      = 0;
    mismatches      = 0;
    cycles          = 0;
    rx_hold_req     = 0;
    rx_stall_left   = 0;
    tx_idle_en      = 1'b1;
    rx_idle_en      = 1'b1;
    reset_tracking();

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_command_sequences(500, 1'b0, 1'b0);
    test_command_sequences(500, 1'b1, 1'b1);
    test_noise(300);
    test_config_extremes();
    test_output_backpressure();

    // Last stretch at full rate on both sides.
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_command_sequences(250, 1'b1, 1'b1);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("stick_gesture_command_detector_tb passed");
    end else begin
      $display("stick_gesture_command_detector_tb failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/sgcd_pkg.sv
design/sgcd_classify.sv
design/sgcd_hist_cell.sv
design/stick_gesture_command_detector.sv
tb/stick_gesture_command_detector_tb.sv
